@@ rtl/core/ipv4dq_pkg.sv @@
// Shared types and character constants for the dotted-quad address parser.
`timescale 1ns / 1ps

package ipv4dq_pkg;

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChDot  = 8'h2E;
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [1:0] LastOctet = 2'd3;

  typedef enum logic [1:0] {
    ClsDigit,
    ClsDot,
    ClsNul,
    ClsOther
  } char_class_e;

  typedef struct packed {
    logic [31:0] address;
    logic        malformed;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } result_push_t;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    if (c inside {[ChZero:ChNine]}) begin
      cls = ClsDigit;
    end else if (c == ChDot) begin
      cls = ClsDot;
    end else if (c == ChNul) begin
      cls = ClsNul;
    end else begin
      cls = ClsOther;
    end
    return cls;
  endfunction

endpackage

@@ rtl/core/ipv4dq_if.sv @@
// Handshake channels: character words in, address words out.
`timescale 1ns / 1ps

interface ipv4dq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface ipv4dq_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        malformed;

  modport source (output valid, output address, output malformed, input ready);
  modport sink   (input valid, input address, input malformed, output ready);
endinterface

@@ rtl/core/ipv4dq_parse.sv @@
// Input register, parse state and per-character update.
`timescale 1ns / 1ps

module ipv4dq_parse (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              in_char_i,
  input  logic                    stall_i,
  output ipv4dq_pkg::result_push_t push_o
);
  import ipv4dq_pkg::*;

  logic        char_valid_q;
  logic [7:0]  char_q;
  logic [1:0]  pos_q, pos_d;
  logic [7:0]  acc_q, acc_d;
  logic [23:0] part_q, part_d;
  logic        disc_q, disc_d;
  logic        take;
  logic [31:0] closed;
  logic [7:0]  digit;
  char_class_e cls;

  assign take       = char_valid_q && !stall_i;
  assign in_ready_o = !char_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      char_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= in_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      acc_q  <= '0;
      part_q <= '0;
      disc_q <= 1'b0;
    end else if (take) begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      part_q <= part_d;
      disc_q <= disc_d;
    end
  end

  always_comb begin
    case (pos_q)
      2'd0:    closed = {8'h00, part_q[23:8], acc_q};
      2'd1:    closed = {8'h00, part_q[23:16], acc_q, part_q[7:0]};
      2'd2:    closed = {8'h00, acc_q, part_q[15:0]};
      default: closed = {acc_q, part_q};
    endcase
  end

  assign cls   = classify(char_q);
  assign digit = char_q - ChZero;

  always_comb begin
    pos_d  = pos_q;
    acc_d  = acc_q;
    part_d = part_q;
    disc_d = disc_q;
    push_o = '0;
    if (disc_q) begin
      if (cls == ClsNul) begin
        disc_d = 1'b0;
      end
    end else begin
      case (cls)
        ClsDigit: begin
          acc_d = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + digit;
        end
        ClsDot: begin
          if (pos_q == LastOctet) begin
            push_o.push = 1'b1;
            push_o.res  = '{address: closed, malformed: 1'b0};
            pos_d  = '0;
            acc_d  = '0;
            part_d = '0;
            disc_d = 1'b1;
          end else begin
            part_d = closed[23:0];
            acc_d  = '0;
            pos_d  = pos_q + 2'd1;
          end
        end
        ClsNul: begin
          push_o.push = 1'b1;
          if (pos_q == LastOctet) begin
            push_o.res = '{address: closed, malformed: 1'b0};
          end else begin
            push_o.res = '{address: 32'h0, malformed: 1'b1};
          end
          pos_d  = '0;
          acc_d  = '0;
          part_d = '0;
        end
        default: begin
          // stray character ends the address early
          push_o.push = 1'b1;
          push_o.res  = '{address: closed, malformed: 1'b0};
          pos_d  = '0;
          acc_d  = '0;
          part_d = '0;
          disc_d = 1'b1;
        end
      endcase
    end
    if (!take) begin
      push_o.push = 1'b0;
    end
  end

endmodule

@@ rtl/core/ipv4dq_out.sv @@
// Result register with skid stage toward the address sink.
`timescale 1ns / 1ps

module ipv4dq_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ipv4dq_pkg::result_push_t push_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ipv4dq_pkg::result_t      out_res_o
);
  import ipv4dq_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop         = main_valid_q && out_ready_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_res_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i.push) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i.push) begin
      if (main_valid_q && !pop) begin
        skid_q <= push_i.res;
      end else begin
        main_q <= push_i.res;
      end
    end
  end

endmodule

@@ rtl/core/ipv4_dotted_quad_parser.sv @@
// Top level of the dotted-quad IPv4 address parser.
// A closing character's address word is registered in the result register, or in the skid stage if that is occupied.
// Throughput: one character word per cycle while the skid stage is empty.
// Input stalls only while the skid stage holds a word the sink has not taken.
// Reset (rst_ni low, asynchronous) clears parse state, discard flag and all valids.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipv4dq_char_if.sink          char_in,
  ipv4dq_addr_if.source        addr_out
);
  import ipv4dq_pkg::*;

  result_push_t push;
  logic         full;
  result_t      res;

  ipv4dq_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_in.valid),
    .in_ready_o (char_in.ready),
    .in_char_i  (char_in.character),
    .stall_i    (full),
    .push_o     (push)
  );

  ipv4dq_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (addr_out.valid),
    .out_ready_i (addr_out.ready),
    .out_res_o   (res)
  );

  assign addr_out.address   = res.address;
  assign addr_out.malformed = res.malformed;

endmodule

@@ bench/ipv4_dotted_quad_parser_test.sv @@
// Self-checking testbench for the dotted-quad IPv4 parser: character words in, address words out.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_test;
  import ipv4dq_pkg::*;

  localparam int StallLimit = 2000;

  logic clk_i;
  logic rst_ni;

  ipv4dq_char_if char_bus ();
  ipv4dq_addr_if addr_bus ();

  ipv4_dotted_quad_parser u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_in  (char_bus.sink),
    .addr_out (addr_bus.source)
  );

  // parser shadow state
  logic [1:0]  octet_idx;
  logic [7:0]  octet_acc;
  logic [23:0] closed_octets;
  bit          skip_tail;

  result_t address_q[$];

  bit quiet;
  int mismatches;
  int stall_cycles;
  int n_chars;
  int n_addresses;
  int n_malformed;

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    addr_bus.ready <= quiet || ($urandom_range(99) >= 16);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h (word %0d)", what, got, want, n_chars);
    mismatches++;
  endtask

  function automatic void clear_octets();
    octet_idx     = '0;
    octet_acc     = '0;
    closed_octets = '0;
  endfunction

  // Advance the shadow parser by one character; queue the address word it yields.
  function automatic void parse_char(input logic [7:0] ch);
    result_t     res;
    logic [31:0] closed;
    bit          emit;
    emit   = 1'b0;
    res    = '0;
    closed = {8'h00, closed_octets} | ({24'h0, octet_acc} << (8 * octet_idx));
    n_chars++;
    if (skip_tail) begin
      if (ch == ChNul) skip_tail = 1'b0;
    end else if (ch >= ChZero && ch <= ChNine) begin
      octet_acc = octet_acc * 8'd10 + (ch - ChZero);
    end else if (ch == ChDot) begin
      if (octet_idx == LastOctet) begin
        res.address = closed;
        emit        = 1'b1;
        skip_tail   = 1'b1;
        clear_octets();
      end else begin
        closed_octets = closed[23:0];
        octet_acc     = '0;
        octet_idx     = octet_idx + 2'd1;
      end
    end else if (ch == ChNul) begin
      emit = 1'b1;
      if (octet_idx == LastOctet) res.address = closed;
      else res.malformed = 1'b1;
      clear_octets();
    end else begin
      // stray character: close here, later octets zero
      res.address = closed;
      emit        = 1'b1;
      skip_tail   = 1'b1;
      clear_octets();
    end
    if (emit) begin
      address_q.push_back(res);
      n_addresses++;
      if (res.malformed) n_malformed++;
    end
  endfunction

  // Entered and left at a falling edge; valid stays high on exit.
  task automatic push_char(input logic [7:0] ch);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < 16) gap = $urandom_range(1, 4);
    repeat (gap) begin
      char_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.character <= ch;
    do @(posedge clk_i); while (char_bus.ready !== 1'b1);
    parse_char(ch);
    @(negedge clk_i);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic wait_drained();
    char_bus.valid <= 1'b0;
    while (address_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= ChZero && c <= ChNine) || c == ChDot);
    return c;
  endfunction

  task automatic push_octet();
    int style;
    style = $urandom_range(99);
    if (style < 70) begin
      push_text($sformatf("%0d", $urandom_range(255)));
    end else if (style < 90) begin
      repeat ($urandom_range(1, 6)) push_char(ChZero + 8'($urandom_range(9)));
    end
  endtask

  // Mostly four octets; some truncated; closed by NUL, a dot or a stray character, with a NUL always at the end.
  task automatic push_address_string();
    int octets;
    int ending;
    octets = ($urandom_range(99) < 80) ? 4 : $urandom_range(0, 3);
    for (int i = 0; i < octets; i++) begin
      if (i > 0) push_char(ChDot);
      push_octet();
    end
    ending = $urandom_range(99);
    if (ending >= 60) begin
      push_char(ending < 75 ? ChDot : stray_char());
      repeat ($urandom_range(0, 4)) push_char(8'($urandom_range(1, 255)));
    end
    push_char(ChNul);
  endtask

  task automatic push_noise_string();
    int kind;
    repeat ($urandom_range(1, 10)) begin
      kind = $urandom_range(99);
      if (kind < 40) push_char(ChZero + 8'($urandom_range(9)));
      else if (kind < 60) push_char(ChDot);
      else push_char(8'($urandom_range(1, 255)));
    end
    push_char(ChNul);
  endtask

  task automatic test_directed_strings();
    push_char(ChNul);                 // empty string
    push_text("255..0.999.:");        // wrap, empty octet, dot closes fourth
    push_char(ChNul);
    push_text("7");
    push_char(8'hFF);                 // stray at first octet
    push_char(ChNul);
    push_text("1.2");                 // truncated
    push_char(ChNul);
    push_text("...");                 // NUL closes empty fourth octet
    push_char(ChNul);
  endtask

  task automatic test_random_strings(input int budget);
    int stop_at;
    stop_at = n_chars + budget;
    while (n_chars < stop_at) push_address_string();
  endtask

  task automatic test_no_idle_stretch(input int budget);
    int stop_at;
    stop_at = n_chars + budget;
    quiet   = 1'b1;
    while (n_chars < stop_at) push_address_string();
    quiet = 1'b0;
  endtask

  task automatic test_noise_strings(input int budget);
    int stop_at;
    stop_at = n_chars + budget;
    while (n_chars < stop_at) begin
      if ($urandom_range(1)) push_noise_string();
      else push_address_string();
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && addr_bus.valid === 1'b1 && addr_bus.ready === 1'b1) begin
      if (address_q.size() == 0) begin
        report_mismatch("unexpected address word", addr_bus.address, '0);
      end else begin
        want = address_q.pop_front();
        if (addr_bus.address !== want.address)
          report_mismatch("address", addr_bus.address, want.address);
        if (addr_bus.malformed !== want.malformed)
          report_mismatch("malformed", {31'h0, addr_bus.malformed}, {31'h0, want.malformed});
      end
    end
  end

  always @(posedge clk_i) begin
    if ((char_bus.valid === 1'b1 && char_bus.ready === 1'b1) ||
        (addr_bus.valid === 1'b1 && addr_bus.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("timeout: no word moved for %0d cycles", stall_cycles);
      $display("ipv4_dotted_quad_parser_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.character = '0;
    addr_bus.ready     = 1'b0;
    quiet              = 1'b0;
    skip_tail          = 1'b0;
    mismatches         = 0;
    stall_cycles       = 0;
    n_chars            = 0;
    n_addresses        = 0;
    n_malformed        = 0;
    clear_octets();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_strings();
    wait_drained();
    test_random_strings(1150);
    wait_drained();
    test_no_idle_stretch(250);
    test_noise_strings(230);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (address_q.size() != 0) report_mismatch("words still expected", address_q.size(), '0);
    $display("covered %0d character words and %0d address words (%0d malformed)",
             n_chars, n_addresses, n_malformed);
    $display("edge strings, random and truncated addresses, noise, idle and stall mixes");
    if (mismatches == 0) begin
      $display("ipv4_dotted_quad_parser_test: PASS");
    end else begin
      $display("ipv4_dotted_quad_parser_test: FAIL");
    end
    $finish;
  end

endmodule
